// ===== rtl/core/sgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_pkg
// Types and constants shared by the serial gamepad port modules.
// ----------------------------------------------------------------------------
package sgp_pkg;

   // Bus operation codes carried in a request word
   typedef enum logic [2:0] {
      OP_READ_DATA    = 3'd0,
      OP_READ_STATUS  = 3'd1,
      OP_WRITE_DATA   = 3'd2,
      OP_WRITE_STATUS = 3'd3,
      OP_WRITE_CTRL   = 3'd4,
      OP_TICK         = 3'd5
   } op_type;

   // Poll exchange progress
   typedef enum logic [2:0] {
      XS_IDLE  = 3'd0,
      XS_SEL   = 3'd1,
      XS_ID    = 3'd2,
      XS_READY = 3'd3,
      XS_LOW   = 3'd4,
      XS_HIGH  = 3'd5,
      XS_DONE  = 3'd6
   } xstate_type;

   // Configuration register indexes
   localparam logic CSR_PAD_ID    = 1'b0;
   localparam logic CSR_ACK_DELAY = 1'b1;

   localparam logic [7:0]  PAD_ID_RESET    = 8'd65;
   localparam logic [15:0] ACK_DELAY_RESET = 16'd100;

   // Protocol bytes
   localparam logic [7:0] BYTE_SELECT = 8'h01;
   localparam logic [7:0] BYTE_POLL   = 8'h42;
   localparam logic [7:0] BYTE_READY  = 8'h5A;
   localparam logic [7:0] BYTE_IDLE   = 8'hFF;

   // Status bit positions
   localparam int STAT_TX_READY = 0;
   localparam int STAT_RX_READY = 1;
   localparam int STAT_ACK      = 7;
   localparam int STAT_IRQ      = 9;

   // Control bit positions
   localparam int CTL_SELECT = 1;
   localparam int CTL_IRQ_ACK = 4;
   localparam int CTL_RESET  = 6;
   localparam int CTL_IRQ_EN = 12;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] write_value;
      logic [15:0] tick_cycles;
      logic [15:0] button_lines;
      logic        pad_present;
   } req_type;

   typedef struct packed {
      logic [9:0] read_value;
      logic       irq_request;
   } rsp_type;

endpackage

// ===== rtl/core/serial_gamepad_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_gamepad_port
// Bus-mapped gamepad port: poll exchange, status, acknowledge countdown.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_stall is low, either a bus access or a
// tick, and returns one result word for each, in order. A word is captured in
// an input register; when the output register can take its result, the port
// state is updated and the result lands in the output register, which drives
// rsp_valid. Words flow at one per cycle while the reply channel does not
// stall. The port state update is combinational. While the output register
// is full and stalled, one more word waits in the input register, then
// req_stall rises. Configuration writes (pad_id at index 0, ack_delay at
// index 1) take effect at the next edge and belong to idle periods.
// ----------------------------------------------------------------------------
module serial_gamepad_port (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sgp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sgp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   logic             in_valid_ff;
   sgp_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   sgp_pkg::rsp_type out_data_ff;
   sgp_pkg::rsp_type step_rsp;
   logic             advance;

   // Process the held word when the output register can take its result
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   sgp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .step_req (in_data_ff),
      .step_rsp (step_rsp),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/core/sgp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_core
// Port state and its next-state update for one bus access or tick.
// ----------------------------------------------------------------------------
module sgp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  sgp_pkg::req_type step_req,
   output sgp_pkg::rsp_type step_rsp,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   logic [7:0]          pad_id_ff;
   logic [15:0]         ack_delay_ff;
   sgp_pkg::xstate_type xstate_ff, xstate_in;
   logic [7:0]          rx_byte_ff, rx_byte_in;
   logic                rx_ready_ff, rx_ready_in;
   logic [9:0]          status_ff, status_in;
   logic [15:0]         ctrl_ff, ctrl_in;
   logic [15:0]         countdown_ff, countdown_in;
   sgp_pkg::op_type     op;
   logic [7:0]          tx_byte;
   logic                ack;
   logic [7:0]          ack_byte;

   assign op      = sgp_pkg::op_type'(step_req.operation);
   assign tx_byte = step_req.write_value[7:0];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_id_ff    <= sgp_pkg::PAD_ID_RESET;
         ack_delay_ff <= sgp_pkg::ACK_DELAY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sgp_pkg::CSR_PAD_ID:    pad_id_ff    <= csr_wdata[7:0];
            sgp_pkg::CSR_ACK_DELAY: ack_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state and result for the word in flight
   always_comb begin
      xstate_in    = xstate_ff;
      rx_byte_in   = rx_byte_ff;
      rx_ready_in  = rx_ready_ff;
      status_in    = status_ff;
      ctrl_in      = ctrl_ff;
      countdown_in = countdown_ff;
      step_rsp     = '0;
      ack          = 1'b0;
      ack_byte     = sgp_pkg::BYTE_IDLE;

      case (op)
         sgp_pkg::OP_READ_DATA: begin
            status_in[sgp_pkg::STAT_RX_READY] = 1'b0;
            step_rsp.read_value = {2'b00, rx_byte_ff};
         end
         sgp_pkg::OP_READ_STATUS: begin
            step_rsp.read_value = status_ff;
            step_rsp.read_value[sgp_pkg::STAT_TX_READY] = 1'b1;
            if (rx_ready_ff) begin
               step_rsp.read_value[sgp_pkg::STAT_RX_READY] = 1'b1;
            end
         end
         sgp_pkg::OP_WRITE_DATA: begin
            if (!step_req.pad_present) begin
               rx_byte_in = sgp_pkg::BYTE_IDLE;
            end else begin
               case (xstate_ff)
                  sgp_pkg::XS_SEL: begin
                     if (tx_byte == sgp_pkg::BYTE_POLL) begin
                        ack       = 1'b1;
                        ack_byte  = pad_id_ff;
                        xstate_in = sgp_pkg::XS_ID;
                     end else begin
                        xstate_in = sgp_pkg::XS_IDLE;
                     end
                  end
                  sgp_pkg::XS_ID: begin
                     ack       = 1'b1;
                     ack_byte  = sgp_pkg::BYTE_READY;
                     xstate_in = sgp_pkg::XS_READY;
                  end
                  sgp_pkg::XS_READY: begin
                     ack       = 1'b1;
                     ack_byte  = step_req.button_lines[7:0];
                     xstate_in = sgp_pkg::XS_LOW;
                  end
                  sgp_pkg::XS_LOW: begin
                     ack       = 1'b1;
                     ack_byte  = step_req.button_lines[15:8];
                     xstate_in = sgp_pkg::XS_HIGH;
                  end
                  sgp_pkg::XS_HIGH: xstate_in = sgp_pkg::XS_DONE;
                  sgp_pkg::XS_DONE: xstate_in = sgp_pkg::XS_IDLE;
                  default: begin
                     // idle, and the unused code that behaves as idle
                     if (tx_byte == sgp_pkg::BYTE_SELECT) begin
                        ack       = 1'b1;
                        xstate_in = sgp_pkg::XS_SEL;
                     end else begin
                        xstate_in = sgp_pkg::XS_IDLE;
                     end
                  end
               endcase
               rx_byte_in = ack_byte;
               if (ack) begin
                  rx_ready_in                  = 1'b1;
                  status_in[sgp_pkg::STAT_ACK] = 1'b1;
                  countdown_in                 = ack_delay_ff;
               end
            end
         end
         sgp_pkg::OP_WRITE_STATUS: begin
            status_in[sgp_pkg::STAT_IRQ] = 1'b0;
         end
         sgp_pkg::OP_WRITE_CTRL: begin
            ctrl_in = step_req.write_value;
            if (step_req.write_value[sgp_pkg::CTL_IRQ_ACK]) begin
               status_in[sgp_pkg::STAT_IRQ] = 1'b0;
            end
            if (step_req.write_value[sgp_pkg::CTL_RESET]) begin
               xstate_in   = sgp_pkg::XS_IDLE;
               status_in   = '0;
               rx_ready_in = 1'b0;
            end
            // select released: drop back to idle
            if (ctrl_ff[sgp_pkg::CTL_SELECT] && !step_req.write_value[sgp_pkg::CTL_SELECT]) begin
               xstate_in   = sgp_pkg::XS_IDLE;
               rx_ready_in = 1'b0;
            end
         end
         sgp_pkg::OP_TICK: begin
            if (countdown_ff != '0) begin
               if (step_req.tick_cycles >= countdown_ff) begin
                  countdown_in = '0;
                  if (ctrl_ff[sgp_pkg::CTL_IRQ_EN]) begin
                     status_in[sgp_pkg::STAT_IRQ] = 1'b1;
                     step_rsp.irq_request         = 1'b1;
                  end
               end else begin
                  countdown_in = countdown_ff - step_req.tick_cycles;
               end
            end
         end
         default: ;
      endcase
   end

   // Port state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xstate_ff    <= sgp_pkg::XS_IDLE;
         rx_byte_ff   <= sgp_pkg::BYTE_IDLE;
         rx_ready_ff  <= 1'b0;
         status_ff    <= '0;
         ctrl_ff      <= '0;
         countdown_ff <= '0;
      end else if (step_en) begin
         xstate_ff    <= xstate_in;
         rx_byte_ff   <= rx_byte_in;
         rx_ready_ff  <= rx_ready_in;
         status_ff    <= status_in;
         ctrl_ff      <= ctrl_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

// ===== tb/sgp_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_reply_checker
// Reply predictor and scoreboard for the serial gamepad port.
// ----------------------------------------------------------------------------
// Watches the request, reply and register channels of the port. Each accepted
// request word runs through a local copy of the port state: the poll
// exchange, the status bits, the control word and the acknowledge countdown.
// The reply it should produce is queued. Each accepted reply word is compared
// field by field with the oldest queued reply. Failures are counted and handed
// to the testbench top together with the number of replies still owed.
// ----------------------------------------------------------------------------
module sgp_reply_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sgp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sgp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending_words
);
   import sgp_pkg::*;

   // Register copies
   logic [7:0]  pad_id_reg;
   logic [15:0] ack_delay_reg;

   // Port state copies
   xstate_type  xchg_state;
   logic [7:0]  rx_byte;
   logic        rx_ready;
   logic [9:0]  status_word;
   logic [15:0] ctrl_word;
   logic [15:0] ack_count;

   // Replies owed by the port, oldest first
   rsp_type     owed_replies[$];

   task automatic report_fail(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // Pad sends an acknowledged byte: latch it, flag it, restart the countdown
   task automatic load_ack(input xstate_type next_state, input logic [7:0] pad_byte);
      xchg_state              = next_state;
      rx_byte                 = pad_byte;
      rx_ready                = 1'b1;
      status_word[STAT_ACK]   = 1'b1;
      ack_count               = ack_delay_reg;
   endtask

   // Advance the port state by one request word and form its reply
   task automatic predict_reply(input req_type w, output rsp_type r);
      logic [7:0]  tx;
      logic [15:0] prev_ctrl;
      r  = '0;
      tx = w.write_value[7:0];
      case (w.operation)
         OP_READ_DATA: begin
            status_word[STAT_RX_READY] = 1'b0;
            r.read_value = {2'b00, rx_byte};
         end
         OP_READ_STATUS: begin
            r.read_value = status_word;
            r.read_value[STAT_TX_READY] = 1'b1;
            if (rx_ready) begin
               r.read_value[STAT_RX_READY] = 1'b1;
            end
         end
         OP_WRITE_DATA: begin
            if (!w.pad_present) begin
               rx_byte = BYTE_IDLE;
            end else begin
               case (xchg_state)
                  XS_SEL: begin
                     if (tx == BYTE_POLL) begin
                        load_ack(XS_ID, pad_id_reg);
                     end else begin
                        xchg_state = XS_IDLE;
                        rx_byte    = BYTE_IDLE;
                     end
                  end
                  XS_ID:    load_ack(XS_READY, BYTE_READY);
                  XS_READY: load_ack(XS_LOW, w.button_lines[7:0]);
                  XS_LOW:   load_ack(XS_HIGH, w.button_lines[15:8]);
                  XS_HIGH: begin
                     xchg_state = XS_DONE;
                     rx_byte    = BYTE_IDLE;
                  end
                  XS_DONE: begin
                     xchg_state = XS_IDLE;
                     rx_byte    = BYTE_IDLE;
                  end
                  default: begin
                     if (tx == BYTE_SELECT) begin
                        load_ack(XS_SEL, BYTE_IDLE);
                     end else begin
                        xchg_state = XS_IDLE;
                        rx_byte    = BYTE_IDLE;
                     end
                  end
               endcase
            end
         end
         OP_WRITE_STATUS: begin
            status_word[STAT_IRQ] = 1'b0;
         end
         OP_WRITE_CTRL: begin
            prev_ctrl = ctrl_word;
            ctrl_word = w.write_value;
            if (w.write_value[CTL_IRQ_ACK]) begin
               status_word[STAT_IRQ] = 1'b0;
            end
            if (w.write_value[CTL_RESET]) begin
               xchg_state  = XS_IDLE;
               status_word = '0;
               rx_ready    = 1'b0;
            end
            // select falling ends the exchange
            if (prev_ctrl[CTL_SELECT] && !w.write_value[CTL_SELECT]) begin
               xchg_state = XS_IDLE;
               rx_ready   = 1'b0;
            end
         end
         OP_TICK: begin
            if (ack_count != '0) begin
               if (w.tick_cycles >= ack_count) begin
                  ack_count = '0;
                  if (ctrl_word[CTL_IRQ_EN]) begin
                     status_word[STAT_IRQ] = 1'b1;
                     r.irq_request         = 1'b1;
                  end
               end else begin
                  ack_count = ack_count - w.tick_cycles;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Track registers, predict on each accepted request, check each reply
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pad_id_reg    = PAD_ID_RESET;
         ack_delay_reg = ACK_DELAY_RESET;
         xchg_state    = XS_IDLE;
         rx_byte       = BYTE_IDLE;
         rx_ready      = 1'b0;
         status_word   = '0;
         ctrl_word     = '0;
         ack_count     = '0;
         owed_replies.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_PAD_ID) begin
               pad_id_reg = csr_wdata[7:0];
            end else begin
               ack_delay_reg = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_replies.size() == 0) begin
               report_fail($sformatf("reply word %h arrived with none owed", rsp_data));
            end else begin
               want = owed_replies.pop_front();
               if (rsp_data.read_value !== want.read_value) begin
                  report_fail($sformatf("read_value %h, expected %h",
                                        rsp_data.read_value, want.read_value));
               end
               if (rsp_data.irq_request !== want.irq_request) begin
                  report_fail($sformatf("irq_request %b, expected %b",
                                        rsp_data.irq_request, want.irq_request));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_reply(req_data, want);
            owed_replies.push_back(want);
         end
      end
      pending_words = owed_replies.size();
   end

endmodule

// ===== tb/tb_serial_gamepad_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_gamepad_port
// Stimulus and verdict for the serial gamepad port.
// ----------------------------------------------------------------------------
// Drives a directed run through the poll exchange, the interrupt countdown and
// the control and status corner cases, then several phases of random words
// under different register settings. Most random traffic is poll exchanges of
// random length with bus reads and ticks mixed in; the rest is unconstrained
// noise. Both channels idle at random, one phase runs without idling and one
// holds the reply channel off long enough to back up the request channel.
// The checker beside the port predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_serial_gamepad_port;
   import sgp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 170;

   // Codes outside the defined operation set
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic        csr_index   = CSR_PAD_ID;
   logic [15:0] csr_wdata   = '0;
   int          fail_count;
   int          pending_words;
   int          words_sent  = 0;
   int          cycle_count = 0;
   logic        req_gaps_on = 1'b1;
   logic        rsp_gaps_on = 1'b1;
   logic        hold_go     = 1'b0;
   logic        hold_active = 1'b0;

   always #5 clock = ~clock;

   serial_gamepad_port u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sgp_reply_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // Stall replies at random, or solidly during the hold-off
   always @(negedge clock) begin
      rsp_stall <= hold_active || (rsp_gaps_on && ($urandom_range(0, 99) < 25));
   end

   // Hold the reply channel off once, for a counted stretch
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type make_word(input logic [2:0] op, input logic [15:0] wv,
                                         input logic [15:0] ticks, input logic [15:0] btn,
                                         input logic present);
      req_type w;
      w.operation    = op;
      w.write_value  = wv;
      w.tick_cycles  = ticks;
      w.button_lines = btn;
      w.pad_present  = present;
      return w;
   endfunction

   // Mostly short ticks, some anywhere in range, some saturated
   function automatic logic [15:0] rand_ticks();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 16'($urandom_range(0, 64));
      end else if (pick < 85) begin
         return 16'($urandom);
      end
      return 16'hFFFF;
   endfunction

   // Offer one word and hold it until accepted; gaps fall before it
   task automatic send_word(input req_type w);
      @(negedge clock);
      while (req_gaps_on && ($urandom_range(0, 99) < 25)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Drop valid and wait until every owed reply has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Bus read, status access or tick slipped between exchange bytes
   function automatic req_type side_word(input logic [15:0] btn);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         return make_word(OP_READ_DATA, 16'($urandom), rand_ticks(), btn, 1'b1);
      end else if (pick < 60) begin
         return make_word(OP_READ_STATUS, 16'($urandom), rand_ticks(), btn, 1'b1);
      end else if (pick < 90) begin
         return make_word(OP_TICK, 16'($urandom), rand_ticks(), btn, 1'b1);
      end
      return make_word(OP_WRITE_STATUS, 16'($urandom), rand_ticks(), btn, 1'b1);
   endfunction

   // One exchange byte, sometimes corrupted or sent with the pad unplugged
   task automatic send_byte(input logic [7:0] tx, input logic [15:0] btn);
      logic [7:0] sent;
      logic       present;
      if ($urandom_range(0, 9) < 3) begin
         send_word(side_word(btn));
      end
      sent    = ($urandom_range(0, 99) < 5) ? 8'($urandom) : tx;
      present = ($urandom_range(0, 99) >= 5);
      send_word(make_word(OP_WRITE_DATA, {8'($urandom), sent}, rand_ticks(), btn, present));
   endtask

   // Control write, select, poll, then random exchange bytes and side words
   task automatic run_poll_sequence();
      logic [15:0] ctl;
      logic [15:0] btn;
      int          tail;
      btn               = 16'($urandom);
      ctl               = '0;
      ctl[CTL_SELECT]   = 1'b1;
      ctl[CTL_IRQ_EN]   = ($urandom_range(0, 3) != 0);
      ctl[CTL_IRQ_ACK]  = ($urandom_range(0, 3) == 0);
      send_word(make_word(OP_WRITE_CTRL, ctl, rand_ticks(), btn, 1'b1));
      send_byte(BYTE_SELECT, btn);
      send_byte(BYTE_POLL, btn);
      tail = $urandom_range(1, 5);
      for (int i = 0; i < tail; i++) begin
         send_byte(8'($urandom), btn);
      end
      for (int i = 0; i < 2; i++) begin
         send_word(side_word(btn));
      end
      // release select now and then
      if ($urandom_range(0, 9) < 3) begin
         ctl[CTL_SELECT] = 1'b0;
         send_word(make_word(OP_WRITE_CTRL, ctl, rand_ticks(), btn, 1'b1));
      end
   endtask

   // Set the registers while idle, then mix exchanges with noise
   task automatic run_phase(input logic [7:0] pad_id, input logic [15:0] ack_delay);
      int stop_at;
      drain();
      write_csr(CSR_PAD_ID, {8'h00, pad_id});
      write_csr(CSR_ACK_DELAY, ack_delay);
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            run_poll_sequence();
         end else begin
            send_word(make_word(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Full exchange at reset settings, then countdown and interrupt
      send_word(make_word(OP_READ_STATUS, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_READ_DATA, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_CTRL, 16'((1 << CTL_IRQ_EN) | (1 << CTL_SELECT)),
                          16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_DATA, {8'h00, BYTE_SELECT}, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, {8'h00, BYTE_POLL}, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_READ_DATA, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'hFFFF, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_READ_STATUS, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'h0000, 16'h0000, 16'h00FF, 1'b1));
      send_word(make_word(OP_TICK, 16'h0000, 16'd40, 16'h0000, 1'b1));
      send_word(make_word(OP_TICK, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));
      send_word(make_word(OP_READ_STATUS, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_STATUS, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
      // countdown already expired: tick does nothing
      send_word(make_word(OP_TICK, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));
      // wrong byte while idle, then wrong byte after select
      send_word(make_word(OP_WRITE_DATA, {8'h00, BYTE_POLL}, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_DATA, {8'h00, BYTE_SELECT}, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_DATA, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_DATA, {8'h00, BYTE_SELECT}, 16'h0000, 16'hFFFF, 1'b0));
      // interrupt acknowledge with select falling, then full reset
      send_word(make_word(OP_WRITE_CTRL, 16'(1 << CTL_IRQ_ACK), 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_WRITE_CTRL, 16'(1 << CTL_RESET), 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(OP_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_word(make_word(OP_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

      // Random phases across register settings
      run_phase(8'd0, 16'd1);

      drain();
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      run_phase(8'd255, 16'hFFFF);

      drain();
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
      hold_go = 1'b1;
      run_phase(8'($urandom), 16'd0);

      run_phase(8'($urandom), 16'($urandom_range(1, 300)));
      run_phase(8'($urandom), 16'($urandom_range(1, 65535)));

      drain();
      repeat (5) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sgp_pkg.sv
rtl/core/sgp_core.sv
rtl/core/serial_gamepad_port.sv
tb/sgp_reply_checker.sv
tb/tb_serial_gamepad_port.sv
